// ----- rtl/shb_pkg.sv -----
// ============================================================================
// Signal histogram binner: shared package
// Widths, codes and state encoding used by the histogram binner modules.
// ============================================================================
package shb_pkg;

    // Histogram geometry and sample format
    localparam int NUM_BINS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int BIN_BITS    = $clog2(NUM_BINS);
    localparam int COUNT_BITS  = 32;

    // Value path widths
    localparam int POWER_BITS = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS  = SAMPLE_BITS;
    localparam int STEP_BITS  = $clog2(ROOT_BITS);
    localparam int VAL_BITS   = POWER_BITS + 1;
    localparam int MIN_BITS   = 34;
    localparam int DIFF_BITS  = ((VAL_BITS > MIN_BITS) ? VAL_BITS : MIN_BITS) + 1;
    localparam int INV_BITS   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * INV_BITS;
    localparam int IDX_BITS   = PROD_BITS + 1 - FRAC_BITS;

    localparam logic [PROD_BITS:0] ROUND_HALF  = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [63:0]        POWER_LIMIT = 64'h4000_0000_0000_0000;
    localparam logic [INV_BITS-1:0] INV_RESET  = INV_BITS'(65536);

    // Port field widths
    localparam int OP_BITS        = 2;
    localparam int FIELD_BIN_BITS = 8;
    localparam int IN_DATA_BITS   = 40;
    localparam int OUT_DATA_BITS  = 96;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 34;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_REAL  = 2'd0,
        MODE_POWER = 2'd1,
        MODE_AMPL  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VALUE_MODE = 2'd0,
        CFG_RANGE_MIN  = 2'd1,
        CFG_INV_WIDTH  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POWER,
        S_ROOT,
        S_DIFF,
        S_MUL,
        S_LOOKUP,
        S_UPDATE,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/shb_ram.sv -----
// ============================================================================
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ============================================================================
module shb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/shb_isqrt.sv -----
// ============================================================================
// Iterative integer square root
// Restoring bit-pair square root, one result bit per cycle.
// ============================================================================
module shb_isqrt
    import shb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [POWER_BITS-1:0] i_radicand,
    output logic                  o_done,
    output logic [ROOT_BITS-1:0]  o_root
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_cnt;
    logic [POWER_BITS-1:0] r_num;
    logic [POWER_BITS-1:0] r_root;

    logic [POWER_BITS-1:0] w_bit;
    logic [POWER_BITS:0]   w_trial;
    logic                  w_fit;

    assign w_bit   = POWER_BITS'(1) << {r_cnt, 1'b0};
    assign w_trial = (POWER_BITS + 1)'(r_root) + (POWER_BITS + 1)'(w_bit);
    assign w_fit   = (POWER_BITS + 1)'(r_num) >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_radicand;
            r_root <= '0;
            r_cnt  <= STEP_BITS'(ROOT_BITS - 1);
        end else if (r_busy) begin
            if (w_fit) begin
                r_num  <= r_num - w_trial[POWER_BITS-1:0];
                r_root <= (r_root >> 1) + w_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_cnt <= r_cnt - STEP_BITS'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_BITS-1:0];

endmodule

// ----- rtl/signal_histogram_binner_core.sv -----
// ============================================================================
// Signal histogram binner core
// Bins samples into a histogram of equal-width bins held in on-chip RAM.
// ============================================================================
//
// Channel      Direction  Beat contents
// s_axis       in         tuser: opcode; tdata: sample_real, sample_imag, bin_index
// m_axis       out        tdata: bin_count, under_count, total_count (reads only)
// cfg          in         i_cfg_index selects the register, i_cfg_data carries it
//
// An add-sample beat runs the difference, multiply, lookup and update states,
// after the power state in power and amplitude modes and the 16-step square-root
// unit in amplitude mode. The bin read-modify-write through the registered-read
// RAM spans lookup and update. A read beat passes through the result state.
// Reset clears the counters and the per-bin valid bits at once; no sweep.
// A read result that is not taken holds the core in its result state; the
// next beat is still accepted as soon as the result sits in the output register.
//
module signal_histogram_binner_core
    import shb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tuser: [1:0] opcode
    input  logic [OP_BITS-1:0]       s_axis_tuser,
    // tdata: [15:0] sample_real, [31:16] sample_imag, [39:32] bin_index
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: [31:0] bin_count, [63:32] under_count, [95:64] total_count
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // Configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [1:0]                r_value_mode;
    logic signed [MIN_BITS-1:0] r_range_min;
    logic [INV_BITS-1:0]       r_inv_width;

    logic signed [SAMPLE_BITS-1:0] r_re;
    logic signed [SAMPLE_BITS-1:0] r_im;
    logic [POWER_BITS-1:0]     r_power;
    logic                      r_neg;
    logic                      r_big;
    logic [INV_BITS-1:0]       r_dmag;
    logic [PROD_BITS-1:0]      r_prod;
    logic                      r_under;
    logic                      r_hit;
    logic [BIN_BITS-1:0]       r_addr;
    logic                      r_rd_oob;

    logic [NUM_BINS-1:0]       r_valid;
    logic [COUNT_BITS-1:0]     r_under_cnt;
    logic [COUNT_BITS-1:0]     r_total_cnt;

    logic                      r_out_valid;
    logic [OUT_DATA_BITS-1:0]  r_out_data;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_ready;
    logic                      w_ram_re;
    logic                      w_ram_we;
    logic                      w_root_start;
    logic                      w_load_out;
    logic [BIN_BITS-1:0]       w_raddr;
    logic [COUNT_BITS-1:0]     w_ram_rdata;
    logic [COUNT_BITS-1:0]     w_old;
    logic [COUNT_BITS-1:0]     w_bin_count;

    logic [OP_BITS-1:0]        w_op;
    logic signed [SAMPLE_BITS-1:0] w_in_re;
    logic signed [SAMPLE_BITS-1:0] w_in_im;
    logic [FIELD_BIN_BITS-1:0] w_in_bin;
    logic                      w_root_path;

    logic signed [POWER_BITS-1:0] w_sq_re;
    logic signed [POWER_BITS-1:0] w_sq_im;
    logic [POWER_BITS-1:0]     w_power;
    logic                      w_root_done;
    logic [ROOT_BITS-1:0]      w_root;

    logic signed [VAL_BITS-1:0]  w_value;
    logic signed [DIFF_BITS-1:0] w_diff;
    logic [DIFF_BITS-1:0]      w_dmag;

    logic [PROD_BITS:0]        w_round;
    logic [IDX_BITS-1:0]       w_idx_mag;
    logic                      w_inv_zero;
    logic                      w_idx_zero;
    logic                      w_under;
    logic                      w_hit;

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    assign w_op     = s_axis_tuser;
    assign w_in_re  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_in_im  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_in_bin = s_axis_tdata[2*SAMPLE_BITS+FIELD_BIN_BITS-1:2*SAMPLE_BITS];

    assign w_in_acc   = s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Power and amplitude modes go through the squaring stage first; the
    // unused mode code behaves as the real-part mode.
    always_comb begin
        unique case (t_mode'(r_value_mode))
            MODE_POWER: w_root_path = 1'b0;
            MODE_AMPL:  w_root_path = 1'b1;
            MODE_REAL:  w_root_path = 1'b0;
            default:    w_root_path = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_mode <= MODE_REAL;
            r_range_min  <= '0;
            r_inv_width  <= INV_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_VALUE_MODE: r_value_mode <= i_cfg_data[1:0];
                CFG_RANGE_MIN:  r_range_min  <= $signed(i_cfg_data[MIN_BITS-1:0]);
                CFG_INV_WIDTH:  r_inv_width  <= i_cfg_data[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (t_opcode'(w_op))
                        OP_ADD: begin
                            if ((t_mode'(r_value_mode) == MODE_POWER) ||
                                (t_mode'(r_value_mode) == MODE_AMPL)) begin
                                n_state = S_POWER;
                            end else begin
                                n_state = S_DIFF;
                            end
                        end
                        OP_READ:  n_state = S_RESULT;
                        OP_CLEAR: n_state = S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_POWER:  n_state = w_root_path ? S_ROOT : S_DIFF;
            S_ROOT:   n_state = w_root_done ? S_DIFF : S_ROOT;
            S_DIFF:   n_state = S_MUL;
            S_MUL:    n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            S_RESULT: n_state = w_out_free ? S_IDLE : S_RESULT;
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb begin
        w_ready      = 1'b0;
        w_ram_re     = 1'b0;
        w_ram_we     = 1'b0;
        w_root_start = 1'b0;
        w_load_out   = 1'b0;
        w_raddr      = w_idx_mag[BIN_BITS-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_ready  = 1'b1;
                w_ram_re = w_in_acc && (t_opcode'(w_op) == OP_READ);
                w_raddr  = BIN_BITS'(w_in_bin);
            end
            S_POWER:  w_root_start = w_root_path;
            S_LOOKUP: w_ram_re = 1'b1;
            S_UPDATE: w_ram_we = r_hit;
            S_RESULT: w_load_out = w_out_free;
            S_ROOT, S_DIFF, S_MUL: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_axis_tready = w_ready;

    // ------------------------------------------------------------------
    // Value path: squares, square root, offset, scaling and rounding
    // ------------------------------------------------------------------
    assign w_sq_re = r_re * r_re;
    assign w_sq_im = r_im * r_im;
    assign w_power = $unsigned(w_sq_re) + $unsigned(w_sq_im);

    shb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_power),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // Power is checked against 2^62 before binning; 16-bit samples keep it at most 2^31.
    always_comb begin
        unique case (t_mode'(r_value_mode))
            MODE_POWER: begin
                if (64'(r_power) > POWER_LIMIT) begin
                    w_value = $signed(VAL_BITS'(POWER_LIMIT));
                end else begin
                    w_value = $signed({1'b0, r_power});
                end
            end
            MODE_AMPL: w_value = $signed({{(VAL_BITS - ROOT_BITS){1'b0}}, w_root});
            MODE_REAL: w_value = VAL_BITS'(r_re);
            default:   w_value = VAL_BITS'(r_re);
        endcase
    end

    assign w_diff = DIFF_BITS'(w_value) - DIFF_BITS'(r_range_min);
    assign w_dmag = w_diff[DIFF_BITS-1] ? $unsigned(-w_diff) : $unsigned(w_diff);

    // Round half away from zero on the magnitude; the sign is kept apart.
    assign w_round   = {1'b0, r_prod} + ROUND_HALF;
    assign w_idx_mag = w_round[PROD_BITS:FRAC_BITS];

    // A zero reciprocal sends every sample to bin zero. A distance of 2^32
    // or more lies past the last bin (or below bin zero when negative).
    // A negative distance that rounds to zero still counts in bin zero.
    assign w_inv_zero = (r_inv_width == '0);
    assign w_idx_zero = w_inv_zero || (!r_big && (w_idx_mag == '0));
    assign w_under    = r_neg && !w_idx_zero;
    assign w_hit      = !w_under &&
                        (w_inv_zero || (!r_big && (w_idx_mag < IDX_BITS'(NUM_BINS))));

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_re     <= w_in_re;
            r_im     <= w_in_im;
            r_addr   <= BIN_BITS'(w_in_bin);
            r_rd_oob <= 32'(w_in_bin) >= 32'(NUM_BINS);
        end
        if (r_state == S_POWER) begin
            r_power <= w_power;
        end
        if (r_state == S_DIFF) begin
            r_neg  <= w_diff[DIFF_BITS-1];
            r_big  <= |w_dmag[DIFF_BITS-1:INV_BITS];
            r_dmag <= w_dmag[INV_BITS-1:0];
        end
        if (r_state == S_MUL) begin
            r_prod <= r_dmag * r_inv_width;
        end
        if (r_state == S_LOOKUP) begin
            r_under <= w_under;
            r_hit   <= w_hit;
            r_addr  <= w_idx_mag[BIN_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Bin store. An entry whose valid bit is clear reads as zero, so reset
    // and the clear operation need no pass over the RAM.
    // ------------------------------------------------------------------
    shb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (sat_inc(w_old)),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_old       = r_valid[r_addr] ? w_ram_rdata : '0;
    assign w_bin_count = r_rd_oob ? '0 : w_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_under_cnt <= '0;
            r_total_cnt <= '0;
        end else if (w_in_acc && (t_opcode'(w_op) == OP_CLEAR)) begin
            r_valid     <= '0;
            r_under_cnt <= '0;
            r_total_cnt <= '0;
        end else if (r_state == S_UPDATE) begin
            if (r_hit) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_under) begin
                r_under_cnt <= sat_inc(r_under_cnt);
            end
            r_total_cnt <= sat_inc(r_total_cnt);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {r_total_cnt, r_under_cnt, w_bin_count};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/shb_checker.sv -----
// ============================================================================
// Histogram binner port checker
// Concurrent checks on the core's ports, attached to the core by bind.
// ============================================================================
module shb_checker
    import shb_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic [OP_BITS-1:0]       s_axis_tuser,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic w_in_acc;
    logic w_busy_op;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_busy_op = (s_axis_tuser == OP_ADD) || (s_axis_tuser == OP_READ);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // A fresh result beat must stem from an accepted read beat.
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_in_acc && (s_axis_tuser == OP_READ), 2))
        else $error("result beat without a matching read");

    // Add and read beats occupy the core for at least the following cycle.
    a_busy_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_busy_op |=> !s_axis_tready)
        else $error("input accepted while an operation was in progress");

    // The underflow count never passes the total count.
    a_under_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] <= m_axis_tdata[95:64]))
        else $error("underflow count exceeds total count");

endmodule

bind signal_histogram_binner_core shb_checker u_shb_checker (.*);
